FILE: rtl/core/gbe_pkg.sv
package gbe_pkg;

  localparam int unsigned CHARSET_SIZE     = 256;
  localparam int unsigned MAX_GLYPH_HEIGHT = 8;

  localparam int unsigned FONT_DEPTH = 2048;
  localparam int unsigned FONT_AW    = 11;
  localparam int unsigned ROW_BITS   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 2'd1;

  // Input actions
  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_DRAW = 1'b1;

  typedef struct packed {
    logic                action;
    logic [FONT_AW-1:0]  font_address;
    logic [ROW_BITS-1:0] font_bits;
    logic [7:0]          char_code;
    logic [15:0]         origin_x;
    logic [15:0]         origin_y;
    logic [31:0]         fore_color;
    logic [31:0]         back_color;
    logic                see_through;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [31:0] pixel_color;
    logic        write_enable;
    logic        last_pixel;
  } out_item_t;

endpackage

FILE: rtl/core/gbe_ram.sv
module gbe_ram #(
  parameter int unsigned WIDTH = gbe_pkg::ROW_BITS,
  parameter int unsigned DEPTH = gbe_pkg::FONT_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/glyph_bitmap_expander.sv
// Channel | Direction | Handshake              | Payload
// input   | in        | in_valid_i/in_ready_o  | in_item_i  (gbe_pkg::in_item_t)
// output  | out       | out_valid_o/out_ready_i| out_item_o (gbe_pkg::out_item_t)
// config  | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Loads can follow each other in every cycle while the block is idle.
// A draw issues one font store read per row through the single read port,
// then one pixel per cycle while the output is not stalled.
// Output stalls hold the pixel walk; the output register is free-standing,
// so the next item is taken while the final pixel still waits.
// Reset clears the control state and sets the glyph size to 8x8; the font
// store holds no reset value.
module glyph_bitmap_expander (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  gbe_pkg::in_item_t                    in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output gbe_pkg::out_item_t                   out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gbe_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [gbe_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0] st_q, st_d;

  logic [3:0] width_q, height_q;
  logic [3:0] w_eff, h_eff;
  logic [3:0] w_q, h_q;
  logic [2:0] row_q, row_d;
  logic [2:0] col_q, col_d;
  logic [gbe_pkg::FONT_AW-1:0] base_q;
  logic [11:0] base_full;
  logic [15:0] ox_q, oy_q;
  logic [31:0] fg_q, bg_q;
  logic        see_q;

  logic in_xfer, load_xfer, draw_xfer, draw_go;
  logic out_load, col_last, row_last, bit_set;

  logic                            ram_re;
  logic [gbe_pkg::FONT_AW-1:0]     ram_raddr;
  logic [gbe_pkg::ROW_BITS-1:0]    ram_rdata;

  logic               out_valid_q, out_valid_d;
  gbe_pkg::out_item_t out_q, out_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == ST_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign load_xfer   = in_xfer & (in_item_i.action == gbe_pkg::ACTION_LOAD);
  assign draw_xfer   = in_xfer & (in_item_i.action == gbe_pkg::ACTION_DRAW);

  assign w_eff = (width_q > 4'(gbe_pkg::ROW_BITS)) ? 4'(gbe_pkg::ROW_BITS) : width_q;
  assign h_eff = (height_q > 4'(gbe_pkg::MAX_GLYPH_HEIGHT)) ?
                 4'(gbe_pkg::MAX_GLYPH_HEIGHT) : height_q;

  // Drop draws that produce no pixels
  assign draw_go = draw_xfer && (w_eff != 4'd0) && (h_eff != 4'd0) &&
                   ({1'b0, in_item_i.char_code} < 9'(gbe_pkg::CHARSET_SIZE));

  // Glyph stride uses the raw height register
  assign base_full = 12'(in_item_i.char_code) * 12'(height_q);

  assign ram_re    = (st_q == ST_FETCH);
  assign ram_raddr = base_q + gbe_pkg::FONT_AW'(row_q);

  gbe_ram #(
    .WIDTH (gbe_pkg::ROW_BITS),
    .DEPTH (gbe_pkg::FONT_DEPTH)
  ) u_font (
    .clk_i   (clk_i),
    .we_i    (load_xfer),
    .waddr_i (in_item_i.font_address),
    .wdata_i (in_item_i.font_bits),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Read data holds through the row: no other read is issued in EMIT
  assign out_load = (st_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign col_last = ({1'b0, col_q} + 4'd1) == w_q;
  assign row_last = ({1'b0, row_q} + 4'd1) == h_q;
  assign bit_set  = ram_rdata[3'(gbe_pkg::ROW_BITS - 1) - col_q];

  always_comb begin
    st_d  = st_q;
    row_d = row_q;
    col_d = col_q;
    case (st_q)
      ST_IDLE: begin
        if (draw_go) begin
          st_d  = ST_FETCH;
          row_d = 3'd0;
          col_d = 3'd0;
        end
      end
      ST_FETCH: begin
        st_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          if (col_last) begin
            col_d = 3'd0;
            row_d = row_q + 3'd1;
            st_d  = row_last ? ST_IDLE : ST_FETCH;
          end else begin
            col_d = col_q + 3'd1;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d         = 1'b1;
      out_d.pixel_x       = ox_q + 16'(col_q);
      out_d.pixel_y       = oy_q + 16'(row_q);
      out_d.last_pixel    = col_last & row_last;
      if (bit_set) begin
        out_d.pixel_color  = fg_q;
        out_d.write_enable = 1'b1;
      end else if (see_q) begin
        out_d.pixel_color  = 32'd0;
        out_d.write_enable = 1'b0;
      end else begin
        out_d.pixel_color  = bg_q;
        out_d.write_enable = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      row_q       <= 3'd0;
      col_q       <= 3'd0;
      width_q     <= 4'd8;
      height_q    <= 4'd8;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_index_i == gbe_pkg::CFG_GLYPH_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == gbe_pkg::CFG_GLYPH_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (draw_go) begin
      w_q    <= w_eff;
      h_q    <= h_eff;
      base_q <= base_full[gbe_pkg::FONT_AW-1:0];
      ox_q   <= in_item_i.origin_x;
      oy_q   <= in_item_i.origin_y;
      fg_q   <= in_item_i.fore_color;
      bg_q   <= in_item_i.back_color;
      see_q  <= in_item_i.see_through;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Font reads and loads never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_re && load_xfer))
    else $error("font read overlaps a load");

  // Walk counters stay inside the latched glyph
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EMIT) |-> (({1'b0, col_q} < w_q) && ({1'b0, row_q} < h_q)))
    else $error("pixel walk out of glyph bounds");

  // The final pixel returns the walk to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && col_last && row_last) |=> (st_q == ST_IDLE))
    else $error("walk did not end after final pixel");

  // A fetch is always followed by pixel emission
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FETCH) |=> (st_q == ST_EMIT))
    else $error("fetch not followed by emit");

endmodule
